/* rtl/slbb_pkg.sv */
// ----------------------------------------------------------------------------
// slbb_pkg
// Shared types, register map and constants of the status light controller.
// ----------------------------------------------------------------------------
`default_nettype none

package slbb_pkg;

    localparam int TimerWidthDefault = 16;
    localparam int AddrWidth         = 5;
    localparam int DataWidth         = 32;
    localparam int InDataWidth       = 8;
    localparam int OutDataWidth      = 72;

    localparam logic [15:0] BlinkPeriodReset   = 16'd666;
    localparam logic [15:0] BreathePeriodReset = 16'd15;
    localparam logic [8:0]  BreatheTopReset    = 9'sd100;
    localparam logic [8:0]  BreatheBottomReset = -9'sd10;
    localparam logic [7:0]  LeftLevelReset     = 8'd50;
    localparam logic [7:0]  RightLevelReset    = 8'd50;

    localparam logic [23:0] ColourNone   = 24'h000000;
    localparam logic [23:0] ColourBlue   = 24'h0000FF;
    localparam logic [23:0] ColourYellow = 24'hFFFF00;
    localparam logic [23:0] ColourRed    = 24'hFF0000;

    typedef enum logic [2:0] {
        REG_BLINK_PERIOD   = 3'd0,
        REG_BREATHE_PERIOD = 3'd1,
        REG_BREATHE_TOP    = 3'd2,
        REG_BREATHE_BOTTOM = 3'd3,
        REG_LEFT_LEVEL     = 3'd4,
        REG_RIGHT_LEVEL    = 3'd5
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_OFF        = 4'd0,
        ST_DRIVING    = 4'd1,
        ST_REVERSE    = 4'd2,
        ST_TURN_LEFT  = 4'd3,
        ST_TURN_RIGHT = 4'd4,
        ST_CAUTION    = 4'd5,
        ST_STANDBY    = 4'd6,
        ST_FAULT      = 4'd7,
        ST_CHARGING   = 4'd8
    } status_t;

    typedef struct packed {
        logic        lit;
        logic [23:0] rgb;
        logic [7:0]  bright;
    } drive_t;

    localparam drive_t DriveOff = '{lit: 1'b0, rgb: 24'h000000, bright: 8'h00};

    function automatic logic [23:0] status_colour(input logic [3:0] status);
        logic [23:0] colour;
        case (status)
            ST_DRIVING, ST_REVERSE, ST_TURN_LEFT, ST_TURN_RIGHT: colour = ColourBlue;
            ST_CAUTION, ST_STANDBY: colour = ColourYellow;
            ST_FAULT, ST_CHARGING: colour = ColourRed;
            default: colour = ColourNone;
        endcase
        return colour;
    endfunction

endpackage

`default_nettype wire

/* rtl/status_light_blink_breathe_controller_unit.sv */
// ----------------------------------------------------------------------------
// status_light_blink_breathe_controller_unit
// Two-strip status light controller with steady, blink and breathe patterns.
// ----------------------------------------------------------------------------
// Each input word is either a one-millisecond tick (tuser low) or a new status
// (tuser high, status in tdata[3:0]), and every word yields exactly one output
// word with the drive of both strips and the shown status. The block takes one
// word per clock while s_axis_tready is high; the state update and the result
// are formed in a single register stage, and each result is registered.
// A two-entry output buffer lets input flow on while a result waits, and
// s_axis_tready only drops when both entries are full.
`default_nettype none

module status_light_blink_breathe_controller_unit #(
    parameter int TIMER_WIDTH = slbb_pkg::TimerWidthDefault
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // [3:0] status, [7:4] zero
    input  wire logic [slbb_pkg::InDataWidth-1:0]  s_axis_tdata,
    // [0] mode
    input  wire logic                              s_axis_tuser,

    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [0] left_lit, [24:1] left_rgb, [32:25] left_bright, [33] right_lit,
    // [57:34] right_rgb, [65:58] right_bright, [69:66] shown_status, [71:70] zero
    output      logic [slbb_pkg::OutDataWidth-1:0] m_axis_tdata,

    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [slbb_pkg::AddrWidth-1:0]    paddr,
    input  wire logic [slbb_pkg::DataWidth-1:0]    pwdata,
    output      logic [slbb_pkg::DataWidth-1:0]    prdata,
    output      logic                              pready
);

    localparam int CmpWidth = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam logic [TIMER_WIDTH-1:0] TimerCap = '1;

    logic [15:0]  blink_period_reg;
    logic [15:0]  breathe_period_reg;
    logic [8:0]   breathe_top_reg;
    logic [8:0]   breathe_bottom_reg;
    logic [7:0]   left_level_reg;
    logic [7:0]   right_level_reg;

    logic         cfg_write;
    logic [2:0]   cfg_index;

    logic [3:0]             status_reg, status_next;
    logic                   blink_armed_reg, blink_armed_next;
    logic [TIMER_WIDTH-1:0] blink_elapsed_reg, blink_elapsed_next;
    logic                   breathe_armed_reg, breathe_armed_next;
    logic [TIMER_WIDTH-1:0] breathe_elapsed_reg, breathe_elapsed_next;
    logic signed [9:0]      breathe_level_reg, breathe_level_next;
    logic                   breathe_rising_reg, breathe_rising_next;
    slbb_pkg::drive_t       left_reg, left_next;
    slbb_pkg::drive_t       right_reg, right_next;

    logic                   in_fire;
    logic                   out_fire;
    logic [3:0]             in_status;
    logic [23:0]            colour;
    logic [TIMER_WIDTH-1:0] blink_inc;
    logic [TIMER_WIDTH-1:0] breathe_inc;
    logic                   blink_over;
    logic                   breathe_over;
    logic signed [9:0]      top_ext;
    logic signed [9:0]      bottom_ext;
    logic                   rising_now;
    logic [slbb_pkg::OutDataWidth-1:0] result;

    logic                              out_valid_reg;
    logic [slbb_pkg::OutDataWidth-1:0] out_data_reg;
    logic                              skid_valid_reg;
    logic [slbb_pkg::OutDataWidth-1:0] skid_data_reg;

    function automatic slbb_pkg::drive_t side_on(input logic [23:0] rgb,
                                                 input logic [7:0] level);
        slbb_pkg::drive_t d;
        d.lit    = 1'b1;
        d.rgb    = rgb;
        d.bright = level;
        return d;
    endfunction

    function automatic slbb_pkg::drive_t side_toggle(input slbb_pkg::drive_t d,
                                                     input logic [23:0] rgb,
                                                     input logic [7:0] level);
        slbb_pkg::drive_t t;
        if (d.lit) begin
            t = slbb_pkg::DriveOff;
        end else begin
            t = side_on(rgb, level);
        end
        return t;
    endfunction

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_period_reg   <= slbb_pkg::BlinkPeriodReset;
            breathe_period_reg <= slbb_pkg::BreathePeriodReset;
            breathe_top_reg    <= slbb_pkg::BreatheTopReset;
            breathe_bottom_reg <= slbb_pkg::BreatheBottomReset;
            left_level_reg     <= slbb_pkg::LeftLevelReset;
            right_level_reg    <= slbb_pkg::RightLevelReset;
        end else if (cfg_write) begin
            case (cfg_index)
                slbb_pkg::REG_BLINK_PERIOD:   blink_period_reg   <= pwdata[15:0];
                slbb_pkg::REG_BREATHE_PERIOD: breathe_period_reg <= pwdata[15:0];
                slbb_pkg::REG_BREATHE_TOP:    breathe_top_reg    <= pwdata[8:0];
                slbb_pkg::REG_BREATHE_BOTTOM: breathe_bottom_reg <= pwdata[8:0];
                slbb_pkg::REG_LEFT_LEVEL:     left_level_reg     <= pwdata[7:0];
                slbb_pkg::REG_RIGHT_LEVEL:    right_level_reg    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            slbb_pkg::REG_BLINK_PERIOD:   prdata = {16'h0000, blink_period_reg};
            slbb_pkg::REG_BREATHE_PERIOD: prdata = {16'h0000, breathe_period_reg};
            slbb_pkg::REG_BREATHE_TOP:    prdata = {23'h000000, breathe_top_reg};
            slbb_pkg::REG_BREATHE_BOTTOM: prdata = {23'h000000, breathe_bottom_reg};
            slbb_pkg::REG_LEFT_LEVEL:     prdata = {24'h000000, left_level_reg};
            slbb_pkg::REG_RIGHT_LEVEL:    prdata = {24'h000000, right_level_reg};
            default:                      prdata = '0;
        endcase
    end

    // Pattern state update.
    assign s_axis_tready = !skid_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign in_status     = s_axis_tdata[3:0];
    assign colour        = slbb_pkg::status_colour(status_reg);

    assign blink_inc    = (blink_elapsed_reg == TimerCap) ? blink_elapsed_reg
                                                          : blink_elapsed_reg + 1'b1;
    assign breathe_inc  = (breathe_elapsed_reg == TimerCap) ? breathe_elapsed_reg
                                                            : breathe_elapsed_reg + 1'b1;
    assign blink_over   = CmpWidth'(blink_inc) > CmpWidth'(blink_period_reg);
    assign breathe_over = CmpWidth'(breathe_inc) > CmpWidth'(breathe_period_reg);

    assign top_ext    = $signed({breathe_top_reg[8], breathe_top_reg});
    assign bottom_ext = $signed({breathe_bottom_reg[8], breathe_bottom_reg});
    assign rising_now = (breathe_level_reg >= top_ext) ? 1'b0 :
                        (breathe_level_reg <= bottom_ext) ? 1'b1 : breathe_rising_reg;

    always_comb begin
        status_next          = status_reg;
        blink_armed_next     = blink_armed_reg;
        blink_elapsed_next   = blink_elapsed_reg;
        breathe_armed_next   = breathe_armed_reg;
        breathe_elapsed_next = breathe_elapsed_reg;
        breathe_level_next   = breathe_level_reg;
        breathe_rising_next  = breathe_rising_reg;
        left_next            = left_reg;
        right_next           = right_reg;
        if (in_fire) begin
            if (s_axis_tuser) begin
                if (in_status != status_reg) begin
                    status_next          = in_status;
                    blink_armed_next     = 1'b0;
                    blink_elapsed_next   = '0;
                    breathe_armed_next   = 1'b0;
                    breathe_elapsed_next = '0;
                    breathe_level_next   = '0;
                    left_next            = slbb_pkg::DriveOff;
                    right_next           = slbb_pkg::DriveOff;
                end
            end else begin
                case (status_reg)
                    slbb_pkg::ST_OFF: begin
                        left_next  = slbb_pkg::DriveOff;
                        right_next = slbb_pkg::DriveOff;
                    end
                    slbb_pkg::ST_DRIVING, slbb_pkg::ST_CAUTION, slbb_pkg::ST_FAULT: begin
                        left_next  = side_on(colour, left_level_reg);
                        right_next = side_on(colour, right_level_reg);
                    end
                    slbb_pkg::ST_REVERSE, slbb_pkg::ST_TURN_LEFT,
                    slbb_pkg::ST_TURN_RIGHT, slbb_pkg::ST_STANDBY: begin
                        if (!blink_armed_reg) begin
                            blink_armed_next   = 1'b1;
                            blink_elapsed_next = '0;
                        end else begin
                            blink_elapsed_next = blink_inc;
                            if (blink_over) begin
                                blink_armed_next = 1'b0;
                                if (status_reg != slbb_pkg::ST_TURN_RIGHT) begin
                                    left_next = side_toggle(left_reg, colour, left_level_reg);
                                end
                                if (status_reg != slbb_pkg::ST_TURN_LEFT) begin
                                    right_next = side_toggle(right_reg, colour,
                                                             right_level_reg);
                                end
                            end
                        end
                    end
                    slbb_pkg::ST_CHARGING: begin
                        if (!breathe_armed_reg) begin
                            breathe_armed_next   = 1'b1;
                            breathe_elapsed_next = '0;
                        end else begin
                            breathe_elapsed_next = breathe_inc;
                            if (breathe_over) begin
                                breathe_armed_next = 1'b0;
                                if (!breathe_level_reg[9]) begin
                                    left_next  = side_on(colour, breathe_level_reg[7:0]);
                                    right_next = side_on(colour, breathe_level_reg[7:0]);
                                end
                                breathe_rising_next = rising_now;
                                breathe_level_next  = rising_now ? breathe_level_reg + 10'sd1
                                                                 : breathe_level_reg - 10'sd1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg          <= slbb_pkg::ST_OFF;
            blink_armed_reg     <= 1'b0;
            blink_elapsed_reg   <= '0;
            breathe_armed_reg   <= 1'b0;
            breathe_elapsed_reg <= '0;
            breathe_level_reg   <= '0;
            breathe_rising_reg  <= 1'b1;
            left_reg            <= slbb_pkg::DriveOff;
            right_reg           <= slbb_pkg::DriveOff;
        end else begin
            status_reg          <= status_next;
            blink_armed_reg     <= blink_armed_next;
            blink_elapsed_reg   <= blink_elapsed_next;
            breathe_armed_reg   <= breathe_armed_next;
            breathe_elapsed_reg <= breathe_elapsed_next;
            breathe_level_reg   <= breathe_level_next;
            breathe_rising_reg  <= breathe_rising_next;
            left_reg            <= left_next;
            right_reg           <= right_next;
        end
    end

    // Result word and output buffer.
    assign result = {2'b00, status_next,
                     right_next.bright, right_next.rgb, right_next.lit,
                     left_next.bright, left_next.rgb, left_next.lit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_fire || !out_valid_reg) begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_fire || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end else if (in_fire) begin
            skid_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* rtl/slbb_checker.sv */
// ----------------------------------------------------------------------------
// slbb_checker
// Port-level checks of the status light controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module slbb_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [slbb_pkg::OutDataWidth-1:0] m_axis_tdata
);

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    // Input back-pressure only appears while a result is waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending result");

    // A dark left side carries neither colour nor brightness; nor does a dark right side while the left is dark.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == 32'h0
            && (m_axis_tdata[33] || m_axis_tdata[65:34] == 32'h0))
        else $error("dark side with colour or brightness");

    // A lit right side always shows one of the status colours.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[33] |->
            m_axis_tdata[57:34] == slbb_pkg::ColourBlue
            || m_axis_tdata[57:34] == slbb_pkg::ColourYellow
            || m_axis_tdata[57:34] == slbb_pkg::ColourRed)
        else $error("right side lit with an unknown colour");

    // A lit left side always shows one of the status colours.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[0] |->
            m_axis_tdata[24:1] == slbb_pkg::ColourBlue
            || m_axis_tdata[24:1] == slbb_pkg::ColourYellow
            || m_axis_tdata[24:1] == slbb_pkg::ColourRed)
        else $error("left side lit with an unknown colour");

endmodule

bind status_light_blink_breathe_controller_unit slbb_checker u_slbb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Status light controller testbench
// Self-checking bench that drives tick and status words into the controller,
// predicts the drive of both strips for every word, and compares each output
// word field by field. Register settings are changed between phases over the
// configuration port, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb;

    typedef enum logic {
        WORD_TICK   = 1'b0,
        WORD_STATUS = 1'b1
    } word_kind_t;

    typedef struct {
        slbb_pkg::drive_t left;
        slbb_pkg::drive_t right;
        logic [3:0]       shown;
    } light_result_t;

    localparam logic [3:0] StatusUnknownLow  = 4'd9;
    localparam logic [3:0] StatusUnknownHigh = 4'd15;
    localparam int         UnusedRegIndex    = 6;

    class light_scoreboard;
        logic [15:0]       blink_period;
        logic [15:0]       breathe_period;
        int                breathe_top;
        int                breathe_bottom;
        logic [7:0]        left_level;
        logic [7:0]        right_level;
        logic [3:0]        shown_status;
        bit                blink_armed;
        bit                breathe_armed;
        bit                breathe_rising;
        longint unsigned   blink_elapsed;
        longint unsigned   breathe_elapsed;
        int                breathe_level;
        slbb_pkg::drive_t  left_drive;
        slbb_pkg::drive_t  right_drive;
        light_result_t     expected_lights[$];
        int                errors;
        int                checked;

        function new();
            blink_period    = slbb_pkg::BlinkPeriodReset;
            breathe_period  = slbb_pkg::BreathePeriodReset;
            breathe_top     = int'($signed(slbb_pkg::BreatheTopReset));
            breathe_bottom  = int'($signed(slbb_pkg::BreatheBottomReset));
            left_level      = slbb_pkg::LeftLevelReset;
            right_level     = slbb_pkg::RightLevelReset;
            shown_status    = slbb_pkg::ST_OFF;
            blink_armed     = 1'b0;
            breathe_armed   = 1'b0;
            breathe_rising  = 1'b1;
            blink_elapsed   = 0;
            breathe_elapsed = 0;
            breathe_level   = 0;
            left_drive      = slbb_pkg::DriveOff;
            right_drive     = slbb_pkg::DriveOff;
            errors          = 0;
            checked         = 0;
        endfunction

        function int pending();
            return expected_lights.size();
        endfunction

        function void write_reg(int idx, logic [31:0] value);
            case (idx)
                slbb_pkg::REG_BLINK_PERIOD:   blink_period = value[15:0];
                slbb_pkg::REG_BREATHE_PERIOD: breathe_period = value[15:0];
                slbb_pkg::REG_BREATHE_TOP:    breathe_top = int'($signed(value[8:0]));
                slbb_pkg::REG_BREATHE_BOTTOM: breathe_bottom = int'($signed(value[8:0]));
                slbb_pkg::REG_LEFT_LEVEL:     left_level = value[7:0];
                slbb_pkg::REG_RIGHT_LEVEL:    right_level = value[7:0];
                default: ;
            endcase
        endfunction

        function slbb_pkg::drive_t lit_drive(logic [23:0] colour, logic [7:0] level);
            slbb_pkg::drive_t d;
            d.lit    = 1'b1;
            d.rgb    = colour;
            d.bright = level;
            return d;
        endfunction

        // The timer arms on its first tick and fires once the count passes
        // the period; the count saturates at the top of the timer width.
        function bit timer_fires(ref bit armed, ref longint unsigned elapsed,
                                 input logic [15:0] period);
            longint unsigned cap;
            cap = (64'd1 << slbb_pkg::TimerWidthDefault) - 1;
            if (!armed) begin
                armed   = 1'b1;
                elapsed = 0;
                return 1'b0;
            end
            if (elapsed < cap) elapsed++;
            if (elapsed > period) begin
                armed = 1'b0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_word(word_kind_t kind, logic [3:0] status);
            light_result_t r;
            logic [23:0]   colour;
            if (kind == WORD_STATUS) begin
                if (status != shown_status) begin
                    shown_status    = status;
                    blink_armed     = 1'b0;
                    blink_elapsed   = 0;
                    breathe_armed   = 1'b0;
                    breathe_elapsed = 0;
                    breathe_level   = 0;
                    left_drive      = slbb_pkg::DriveOff;
                    right_drive     = slbb_pkg::DriveOff;
                end
            end else begin
                case (shown_status)
                    slbb_pkg::ST_DRIVING, slbb_pkg::ST_REVERSE,
                    slbb_pkg::ST_TURN_LEFT, slbb_pkg::ST_TURN_RIGHT:
                        colour = slbb_pkg::ColourBlue;
                    slbb_pkg::ST_CAUTION, slbb_pkg::ST_STANDBY:
                        colour = slbb_pkg::ColourYellow;
                    slbb_pkg::ST_FAULT, slbb_pkg::ST_CHARGING:
                        colour = slbb_pkg::ColourRed;
                    default: colour = slbb_pkg::ColourNone;
                endcase
                case (shown_status)
                    slbb_pkg::ST_OFF: begin
                        left_drive  = slbb_pkg::DriveOff;
                        right_drive = slbb_pkg::DriveOff;
                    end
                    slbb_pkg::ST_DRIVING, slbb_pkg::ST_CAUTION, slbb_pkg::ST_FAULT: begin
                        left_drive  = lit_drive(colour, left_level);
                        right_drive = lit_drive(colour, right_level);
                    end
                    slbb_pkg::ST_REVERSE, slbb_pkg::ST_TURN_LEFT,
                    slbb_pkg::ST_TURN_RIGHT, slbb_pkg::ST_STANDBY: begin
                        if (timer_fires(blink_armed, blink_elapsed, blink_period)) begin
                            if (shown_status != slbb_pkg::ST_TURN_RIGHT)
                                left_drive = left_drive.lit ? slbb_pkg::DriveOff :
                                             lit_drive(colour, left_level);
                            if (shown_status != slbb_pkg::ST_TURN_LEFT)
                                right_drive = right_drive.lit ? slbb_pkg::DriveOff :
                                              lit_drive(colour, right_level);
                        end
                    end
                    slbb_pkg::ST_CHARGING: begin
                        if (timer_fires(breathe_armed, breathe_elapsed, breathe_period)) begin
                            if (breathe_level >= 0) begin
                                left_drive  = lit_drive(colour, 8'(breathe_level));
                                right_drive = lit_drive(colour, 8'(breathe_level));
                            end
                            if (breathe_level >= breathe_top) breathe_rising = 1'b0;
                            else if (breathe_level <= breathe_bottom) breathe_rising = 1'b1;
                            breathe_level += breathe_rising ? 1 : -1;
                        end
                    end
                    default: ;
                endcase
            end
            r.left  = left_drive;
            r.right = right_drive;
            r.shown = shown_status;
            expected_lights.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] e, logic [31:0] a);
            if (a !== e) begin
                errors++;
                if (errors <= 30)
                    $display("%0t mismatch on %s: expected %0h actual %0h",
                             $time, name, e, a);
            end
        endfunction

        function void check_word(logic [slbb_pkg::OutDataWidth-1:0] data);
            light_result_t e;
            if (expected_lights.size() == 0) begin
                errors++;
                $display("%0t unexpected word: expected none actual %0h", $time, data);
                return;
            end
            e = expected_lights.pop_front();
            checked++;
            compare_field("left_lit", 32'(e.left.lit), 32'(data[0]));
            compare_field("left_rgb", 32'(e.left.rgb), 32'(data[24:1]));
            compare_field("left_bright", 32'(e.left.bright), 32'(data[32:25]));
            compare_field("right_lit", 32'(e.right.lit), 32'(data[33]));
            compare_field("right_rgb", 32'(e.right.rgb), 32'(data[57:34]));
            compare_field("right_bright", 32'(e.right.bright), 32'(data[65:58]));
            compare_field("shown_status", 32'(e.shown), 32'(data[69:66]));
        endfunction
    endclass

    logic                                  aclk;
    logic                                  aresetn;
    logic                                  s_axis_tvalid;
    logic                                  s_axis_tready;
    // [3:0] status, [7:4] zero
    logic [slbb_pkg::InDataWidth-1:0]      s_axis_tdata;
    // [0] mode
    logic                                  s_axis_tuser;
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready;
    // [0] left_lit, [24:1] left_rgb, [32:25] left_bright, [33] right_lit,
    // [57:34] right_rgb, [65:58] right_bright, [69:66] shown_status, [71:70] zero
    logic [slbb_pkg::OutDataWidth-1:0]     m_axis_tdata;
    logic                                  psel;
    logic                                  penable;
    logic                                  pwrite;
    logic [slbb_pkg::AddrWidth-1:0]        paddr;
    logic [slbb_pkg::DataWidth-1:0]        pwdata;
    logic [slbb_pkg::DataWidth-1:0]        prdata;
    logic                                  pready;

    light_scoreboard sb = new();
    bit              idle_on = 1'b1;
    int              hold_request = 0;
    int              words_sent = 0;
    int              settings_used = 0;

    status_light_blink_breathe_controller_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(32_000_000);
        $display("tb NOT OK");
        $finish;
    end

    task automatic write_reg(int idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= slbb_pkg::AddrWidth'(idx * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(int blink, int breathe, int top, int bottom,
                             int left, int right);
        write_reg(slbb_pkg::REG_BLINK_PERIOD, 32'(blink) & 32'hFFFF);
        write_reg(slbb_pkg::REG_BREATHE_PERIOD, 32'(breathe) & 32'hFFFF);
        write_reg(slbb_pkg::REG_BREATHE_TOP, 32'(top) & 32'h1FF);
        write_reg(slbb_pkg::REG_BREATHE_BOTTOM, 32'(bottom) & 32'h1FF);
        write_reg(slbb_pkg::REG_LEFT_LEVEL, 32'(left) & 32'hFF);
        write_reg(slbb_pkg::REG_RIGHT_LEVEL, 32'(right) & 32'hFF);
        settings_used++;
    endtask

    task automatic send_word(word_kind_t kind, logic [3:0] status);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'b0000, status};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_word(kind, status);
        words_sent++;
    endtask

    task automatic send_ticks(int count);
        for (int i = 0; i < count; i++) send_word(WORD_TICK, 4'($urandom));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Mostly a status followed by a run of ticks so that the timers fire,
    // with unknown statuses and loose words mixed in.
    task automatic random_phase(int count);
        int sent;
        int run;
        int pick;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                send_word(WORD_STATUS, 4'($urandom_range(0, 8)));
                run = $urandom_range(1, 30);
                send_ticks(run);
                sent += run + 1;
            end else if (pick == 7) begin
                send_word(WORD_STATUS, 4'($urandom));
                sent++;
            end else begin
                send_word(word_kind_t'($urandom_range(0, 1)), 4'($urandom));
                sent++;
            end
        end
    endtask

    task automatic random_settings();
        int blink;
        int breathe;
        int top;
        int bottom;
        blink   = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 65535))
                                              : int'($urandom_range(0, 6));
        breathe = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 40))
                                              : int'($urandom_range(0, 2));
        if ($urandom_range(0, 2) == 0) begin
            top    = int'($urandom_range(0, 510)) - 255;
            bottom = int'($urandom_range(0, 510)) - 255;
        end else begin
            top    = int'($urandom_range(0, 12));
            bottom = -int'($urandom_range(0, 12));
        end
        configure(blink, breathe, top, bottom, $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = 0;
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(1, 7);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
        end
    end

    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        aresetn       <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Steady colours at the reset settings, then unknown statuses.
        send_word(WORD_STATUS, slbb_pkg::ST_OFF);
        send_ticks(1);
        send_word(WORD_STATUS, slbb_pkg::ST_DRIVING);
        send_ticks(1);
        send_word(WORD_STATUS, slbb_pkg::ST_CAUTION);
        send_ticks(1);
        send_word(WORD_STATUS, slbb_pkg::ST_FAULT);
        send_ticks(1);
        send_word(WORD_STATUS, slbb_pkg::ST_CHARGING);
        send_ticks(2);
        send_word(WORD_STATUS, StatusUnknownHigh);
        send_ticks(1);
        send_word(WORD_STATUS, StatusUnknownLow);
        wait_drained();

        // Fast blink and breathe; the write to an unused address must be ignored.
        configure(0, 0, 1, -1, 255, 1);
        write_reg(UnusedRegIndex, 32'hFFFF_FFFF);
        send_word(WORD_STATUS, slbb_pkg::ST_REVERSE);
        send_ticks(4);
        send_word(WORD_STATUS, slbb_pkg::ST_TURN_LEFT);
        send_ticks(2);
        send_word(WORD_STATUS, slbb_pkg::ST_TURN_RIGHT);
        send_ticks(2);
        send_word(WORD_STATUS, slbb_pkg::ST_STANDBY);
        send_ticks(2);
        send_word(WORD_STATUS, slbb_pkg::ST_CHARGING);
        send_ticks(10);
        wait_drained();

        for (int p = 0; p < 10; p++) begin
            idle_on = (p < 8);
            case (p)
                0: configure(0, 0, 255, -255, 255, 0);
                1: configure(1, 65535, -255, 255, 0, 255);
                5: configure(3, 0, 40, -40, 128, 127);
                default: random_settings();
            endcase
            if (p == 2) hold_request = 60;
            if (p == 5) begin
                send_word(WORD_STATUS, slbb_pkg::ST_CHARGING);
                send_ticks(250);
            end else begin
                random_phase(75);
            end
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        $display("Sent %0d words (ticks and status changes) over %0d register settings,",
                 words_sent, settings_used);
        $display("including breathe sweeps, blink toggles and stalls; %0d words checked.",
                 sb.checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
